@@ hdl/i2da_pkg.sv @@
// Shared constants and types for the integer to decimal ASCII converter.
package i2da_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CharWidth  = 7;
  localparam int unsigned MaxDigits  = 10;
  localparam int unsigned CountWidth = $clog2(MaxDigits + 1);
  localparam int unsigned DigitWidth = 4;

  // Reciprocal of ten, exact for every 32-bit dividend with a shift of 35.
  localparam logic [ValueWidth-1:0] DivMult  = 32'hCCCC_CCCD;
  localparam int unsigned           DivShift = 35;

  localparam logic [CharWidth-1:0] CharZero  = 7'h30;
  localparam logic [CharWidth-1:0] CharMinus = 7'h2D;

  typedef struct packed {
    logic                   valid;
    logic [ValueWidth-1:0]  quot;
    logic [DigitWidth-1:0]  rem;
  } div_res_t;

endpackage

@@ hdl/i2da_in_if.sv @@
// Input channel: one signed 32-bit value per request.
interface i2da_in_if;
  import i2da_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [ValueWidth-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

@@ hdl/i2da_out_if.sv @@
// Output channel: one ASCII character per request, with an end-of-text flag.
interface i2da_out_if;
  import i2da_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CharWidth-1:0]  char_code;
  logic                  last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

@@ hdl/i2da_div10.sv @@
// Shared divide-by-ten unit: reciprocal multiply, then remainder.
module i2da_div10 import i2da_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [ValueWidth-1:0]  dividend_i,
  output div_res_t               res_o
);

  logic [2*ValueWidth-1:0]        prod_q;
  logic [ValueWidth-1:0]          dvd_q;
  logic                           busy_q;
  logic                           res_valid_q;
  logic [ValueWidth-1:0]          quot_q;
  logic [DigitWidth-1:0]          rem_q;

  logic [ValueWidth-1:0]          quot_d;
  logic [ValueWidth-1:0]          times10;
  logic [ValueWidth-1:0]          diff;

  always_comb begin
    quot_d  = ValueWidth'(prod_q[2*ValueWidth-1:DivShift]);
    times10 = (quot_d << 3) + (quot_d << 1);
    diff    = dvd_q - times10;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      busy_q      <= start_i;
      res_valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= (2*ValueWidth)'(dividend_i) * (2*ValueWidth)'(DivMult);
      dvd_q  <= dividend_i;
    end
    if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= diff[DigitWidth-1:0];
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.quot  = quot_q;
  assign res_o.rem   = rem_q;

endmodule

@@ hdl/int_to_decimal_ascii.sv @@
// Converts a signed 32-bit integer to its decimal ASCII text, one character per
// output request. A value is accepted only while the converter is idle. It then
// peels off one decimal digit at a time through a shared divide-by-ten unit
// (reciprocal multiply, then remainder), least significant first, and sends the
// characters most significant first: '-' for a negative value, then the digits
// without leading zeros, with last set on the final digit. The next value is
// taken as soon as the final character sits in the output register.
module int_to_decimal_ascii import i2da_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2da_in_if.sink       in_i,
  i2da_out_if.source    out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e                  state_q;
  logic                    neg_q;
  logic [CountWidth-1:0]   cnt_q;
  logic [DigitWidth-1:0]   digit_q [MaxDigits];
  logic                    out_valid_q;
  logic [CharWidth-1:0]    out_char_q;
  logic                    out_last_q;

  logic                    in_fire;
  logic                    out_free;
  logic                    div_start;
  logic [ValueWidth-1:0]   div_dvd;
  logic [ValueWidth-1:0]   in_bits;
  logic [ValueWidth-1:0]   in_mag;
  logic [CountWidth-1:0]   cnt_inc;
  logic [CountWidth-1:0]   cnt_dec;
  logic                    div_last;
  div_res_t                div_res;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    in_bits  = $unsigned(in_i.value);
    in_mag   = in_bits[ValueWidth-1] ? (ValueWidth'(0) - in_bits) : in_bits;
    cnt_inc  = cnt_q + CountWidth'(1);
    cnt_dec  = cnt_q - CountWidth'(1);
    div_last = (div_res.quot == '0) || (cnt_inc == CountWidth'(MaxDigits));
    div_start = 1'b0;
    div_dvd   = in_mag;
    if (in_fire) begin
      div_start = 1'b1;
    end else if (state_q == ST_DIV && div_res.valid && !div_last) begin
      div_start = 1'b1;
      div_dvd   = div_res.quot;
    end
  end

  i2da_div10 u_div10 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .res_o      (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // in ST_EMIT the output register is reloaded whenever it drains
      if (out_valid_q && out_o.ready && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            neg_q   <= in_bits[ValueWidth-1];
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_res.valid) begin
            digit_q[cnt_q[DigitWidth-1:0]] <= div_res.rem;
            cnt_q <= cnt_inc;
            if (div_last) begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (neg_q) begin
              // sign goes out ahead of the digits
              out_char_q <= CharMinus;
              out_last_q <= 1'b0;
              neg_q      <= 1'b0;
            end else begin
              out_char_q <= CharZero + CharWidth'(digit_q[cnt_dec[DigitWidth-1:0]]);
              out_last_q <= (cnt_q == CountWidth'(1));
              cnt_q      <= cnt_dec;
              if (cnt_q == CountWidth'(1)) begin
                state_q <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = out_char_q;
  assign out_o.last      = out_last_q;

  // Divider results only arrive while digits are being collected.
  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.valid |-> state_q == ST_DIV)
    else $error("divider result outside digit collection");

  // Digit count never exceeds the buffer depth.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountWidth'(MaxDigits))
    else $error("digit count out of range");

  // A sign character is never the end of the text.
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_char_q == CharMinus) |-> !out_last_q)
    else $error("sign marked as last character");

  // Loading the final character returns the converter to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free && !neg_q && cnt_q == CountWidth'(1))
      |=> (state_q == ST_IDLE && out_valid_q && out_last_q))
    else $error("final character did not end the item");

endmodule
